[design/hxd_pkg.sv]
// Shared constants, types and helpers of the hex escape XOR line decoder.
package hxd_pkg;

    // Echo store sizing
    localparam int LineMax    = 64;
    localparam int StoreDepth = 64;
    localparam int EchoCap    = (LineMax < StoreDepth) ? LineMax : StoreDepth;
    localparam int AddrW      = (StoreDepth > 1) ? $clog2(StoreDepth) : 1;
    localparam int CountW     = $clog2(EchoCap + 1);

    typedef logic [AddrW-1:0]  addr_t;
    typedef logic [CountW-1:0] count_t;

    // Result kinds
    localparam logic [1:0] KindByte  = 2'd0;
    localparam logic [1:0] KindEcho  = 2'd1;
    localparam logic [1:0] KindError = 2'd2;
    localparam logic [1:0] KindEnd   = 2'd3;

    // Escape parser phases
    localparam logic [1:0] PhIdle  = 2'd0;
    localparam logic [1:0] PhSlash = 2'd1;
    localparam logic [1:0] PhX     = 2'd2;
    localparam logic [1:0] PhFirst = 2'd3;

    // Special characters
    localparam logic [7:0] ChOpen  = 8'h5B;
    localparam logic [7:0] ChClose = 8'h5D;
    localparam logic [7:0] ChX     = 8'h78;
    localparam logic [7:0] ChSlash = 8'h5C;

    // Hex digit decode: bit 4 flags a valid digit, bits 3:0 carry its value
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            r = {1'b1, 4'(c - 8'h30)};
        end
        else if (c >= 8'h61 && c <= 8'h66)
        begin
            r = {1'b1, 4'(c - 8'h57)};
        end
        else if (c >= 8'h41 && c <= 8'h46)
        begin
            r = {1'b1, 4'(c - 8'h37)};
        end
        return r;
    endfunction

endpackage

[design/hxd_char_if.sv]
// Character input channel: valid/ready handshake with one line character.
interface hxd_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;
    logic       line_end;

    modport source (output valid, output ch, output line_end, input ready);
    modport sink   (input valid, input ch, input line_end, output ready);
endinterface

[design/hxd_result_if.sv]
// Result output channel: valid/ready handshake with one decoded result.
interface hxd_result_if;
    logic       valid;
    logic       ready;
    logic [7:0] data;
    logic [1:0] kind;
    logic       last;
    logic       truncated;

    modport source (output valid, output data, output kind, output last,
                    output truncated, input ready);
    modport sink   (input valid, input data, input kind, input last,
                    input truncated, output ready);
endinterface

[design/hex_escape_xor_line_decoder.sv]
// Top level of the hex escape XOR line decoder.
//
// Accepts one line character per cycle while the run state holds and the
// output register is free, and drops bracketed text. Backslash-x escapes
// with two following characters decode to bytes; each byte is committed
// when the next kept character arrives, the first becomes the key and later
// ones leave XORed with it. A non-hex first pair character gives one
// malformed-escape result and kills the rest of the line. A line end that
// carries both a committed result and the end marker sends the marker from
// a separate state. A line that commits no byte and reports no malformed
// escape replays its first 64 kept characters from the echo RAM through a
// registered read at one item per cycle while the receiver is ready, and
// input stalls for that replay. No clearing pass is needed after reset.
module hex_escape_xor_line_decoder (
    input logic         clk,
    input logic         rst_n,
    hxd_char_if.sink    chars,
    hxd_result_if.source results
);

    localparam logic [1:0] ST_RUN  = 2'd0;
    localparam logic [1:0] ST_MARK = 2'd1;
    localparam logic [1:0] ST_ECHO = 2'd2;

    logic [1:0]         state_reg, state_next;
    logic               in_bracket_reg, in_bracket_next;
    logic [1:0]         phase_reg, phase_next;
    logic [3:0]         high_nibble_reg, high_nibble_next;
    logic               pending_valid_reg, pending_valid_next;
    logic               pending_error_reg, pending_error_next;
    logic [7:0]         pending_byte_reg, pending_byte_next;
    logic               key_held_reg, key_held_next;
    logic [7:0]         key_byte_reg, key_byte_next;
    logic               line_dead_reg, line_dead_next;
    hxd_pkg::count_t    echo_count_reg, echo_count_next;
    logic               echo_overflow_reg, echo_overflow_next;
    hxd_pkg::addr_t     echo_idx_reg, echo_idx_next;
    logic               rd_pend_reg, rd_pend_next;

    logic               out_valid_reg, out_valid_next;
    logic [7:0]         out_data_reg, out_data_next;
    logic [1:0]         out_kind_reg, out_kind_next;
    logic               out_last_reg, out_last_next;
    logic               out_trunc_reg, out_trunc_next;

    logic               slot_free;
    logic               accept;
    logic               kept;
    logic               imm_load;
    logic [4:0]         hex;
    logic               clear_line;
    logic               go_echo;

    logic               wr_en;
    hxd_pkg::addr_t     wr_addr;
    logic               rd_en;
    hxd_pkg::addr_t     rd_addr;
    logic [7:0]         rd_data;

    // Echo store
    hxd_ram #(
        .WIDTH (8),
        .DEPTH (hxd_pkg::StoreDepth)
    ) u_echo_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (chars.ch),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign slot_free     = !out_valid_reg || results.ready;
    assign chars.ready   = (state_reg == ST_RUN) && slot_free;
    assign accept        = chars.valid && chars.ready;
    assign kept          = (chars.ch != hxd_pkg::ChOpen) && (chars.ch != hxd_pkg::ChClose)
                           && !in_bracket_reg && !line_dead_reg;
    assign hex           = hxd_pkg::hex_value(chars.ch);

    assign results.valid     = out_valid_reg;
    assign results.data      = out_data_reg;
    assign results.kind      = out_kind_reg;
    assign results.last      = out_last_reg;
    assign results.truncated = out_trunc_reg;

    // Next-state logic: parse, commit, store and replay
    always_comb
    begin
        state_next         = state_reg;
        in_bracket_next    = in_bracket_reg;
        phase_next         = phase_reg;
        high_nibble_next   = high_nibble_reg;
        pending_valid_next = pending_valid_reg;
        pending_error_next = pending_error_reg;
        pending_byte_next  = pending_byte_reg;
        key_held_next      = key_held_reg;
        key_byte_next      = key_byte_reg;
        line_dead_next     = line_dead_reg;
        echo_count_next    = echo_count_reg;
        echo_overflow_next = echo_overflow_reg;
        echo_idx_next      = echo_idx_reg;
        rd_pend_next       = rd_pend_reg;

        out_valid_next = out_valid_reg && !results.ready;
        out_data_next  = out_data_reg;
        out_kind_next  = out_kind_reg;
        out_last_next  = out_last_reg;
        out_trunc_next = out_trunc_reg;

        wr_en      = 1'b0;
        wr_addr    = hxd_pkg::AddrW'(echo_count_reg);
        rd_en      = 1'b0;
        rd_addr    = echo_idx_reg;
        imm_load   = 1'b0;
        clear_line = 1'b0;
        go_echo    = 1'b0;

        case (state_reg)
            ST_RUN:
            begin
                if (accept)
                begin
                    // Brackets
                    if (chars.ch == hxd_pkg::ChOpen)
                    begin
                        in_bracket_next = 1'b1;
                    end
                    else if (chars.ch == hxd_pkg::ChClose)
                    begin
                        in_bracket_next = 1'b0;
                    end

                    if (kept && pending_valid_reg && pending_error_reg)
                    begin
                        // Commit malformed escape: report and kill the line
                        pending_valid_next = 1'b0;
                        pending_error_next = 1'b0;
                        line_dead_next     = 1'b1;
                        imm_load           = 1'b1;
                        out_valid_next     = 1'b1;
                        out_data_next      = 8'd0;
                        out_kind_next      = hxd_pkg::KindError;
                        out_last_next      = 1'b0;
                        out_trunc_next     = 1'b0;
                    end
                    else if (kept)
                    begin
                        // Commit pending byte as key or XORed output
                        if (pending_valid_reg)
                        begin
                            pending_valid_next = 1'b0;
                            if (!key_held_reg)
                            begin
                                key_held_next = 1'b1;
                                key_byte_next = pending_byte_reg;
                            end
                            else
                            begin
                                imm_load       = 1'b1;
                                out_valid_next = 1'b1;
                                out_data_next  = pending_byte_reg ^ key_byte_reg;
                                out_kind_next  = hxd_pkg::KindByte;
                                out_last_next  = 1'b0;
                                out_trunc_next = 1'b0;
                            end
                        end

                        // Store for echo
                        if (echo_count_reg < hxd_pkg::count_t'(hxd_pkg::EchoCap))
                        begin
                            wr_en           = 1'b1;
                            echo_count_next = echo_count_reg + hxd_pkg::count_t'(1);
                        end
                        else
                        begin
                            echo_overflow_next = 1'b1;
                        end

                        // Advance escape parser
                        case (phase_reg)
                            hxd_pkg::PhIdle:
                            begin
                                if (chars.ch == hxd_pkg::ChSlash)
                                begin
                                    phase_next = hxd_pkg::PhSlash;
                                end
                            end
                            hxd_pkg::PhSlash:
                            begin
                                if (chars.ch == hxd_pkg::ChX)
                                begin
                                    phase_next = hxd_pkg::PhX;
                                end
                                else if (chars.ch != hxd_pkg::ChSlash)
                                begin
                                    phase_next = hxd_pkg::PhIdle;
                                end
                            end
                            hxd_pkg::PhX:
                            begin
                                pending_error_next = !hex[4];
                                high_nibble_next   = hex[4] ? hex[3:0] : 4'd0;
                                phase_next         = hxd_pkg::PhFirst;
                            end
                            default:
                            begin
                                pending_byte_next  = hex[4] ? {high_nibble_reg, hex[3:0]}
                                                            : {4'd0, high_nibble_reg};
                                pending_valid_next = 1'b1;
                                phase_next         = hxd_pkg::PhIdle;
                            end
                        endcase
                    end

                    // Line end: echo, or end marker
                    if (chars.line_end)
                    begin
                        clear_line = 1'b1;
                        if (!line_dead_next && !key_held_next && (echo_count_next != '0))
                        begin
                            go_echo       = 1'b1;
                            state_next    = ST_ECHO;
                            echo_idx_next = '0;
                            rd_pend_next  = 1'b0;
                        end
                        else if (imm_load)
                        begin
                            state_next = ST_MARK;
                        end
                        else
                        begin
                            out_valid_next = 1'b1;
                            out_data_next  = 8'd0;
                            out_kind_next  = hxd_pkg::KindEnd;
                            out_last_next  = 1'b1;
                            out_trunc_next = 1'b0;
                        end
                    end
                end
            end

            ST_MARK:
            begin
                // Emit end marker behind the committed result
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = 8'd0;
                    out_kind_next  = hxd_pkg::KindEnd;
                    out_last_next  = 1'b1;
                    out_trunc_next = 1'b0;
                    state_next     = ST_RUN;
                end
            end

            ST_ECHO:
            begin
                // Replay the store: read ahead, hand over when the slot frees
                if (!rd_pend_reg)
                begin
                    rd_en        = 1'b1;
                    rd_pend_next = 1'b1;
                end
                else if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = rd_data;
                    out_kind_next  = hxd_pkg::KindEcho;
                    out_trunc_next = echo_overflow_reg;
                    if (hxd_pkg::count_t'(echo_idx_reg) + hxd_pkg::count_t'(1)
                        == echo_count_reg)
                    begin
                        out_last_next      = 1'b1;
                        state_next         = ST_RUN;
                        rd_pend_next       = 1'b0;
                        echo_count_next    = '0;
                        echo_overflow_next = 1'b0;
                    end
                    else
                    begin
                        out_last_next = 1'b0;
                        echo_idx_next = echo_idx_reg + hxd_pkg::addr_t'(1);
                        rd_en         = 1'b1;
                        rd_addr       = echo_idx_reg + hxd_pkg::addr_t'(1);
                    end
                end
            end

            default:
            begin
                state_next = ST_RUN;
            end
        endcase

        // Return line state to reset; echo bookkeeping stays for the replay
        if (clear_line)
        begin
            in_bracket_next    = 1'b0;
            phase_next         = hxd_pkg::PhIdle;
            high_nibble_next   = 4'd0;
            pending_valid_next = 1'b0;
            pending_error_next = 1'b0;
            pending_byte_next  = 8'd0;
            key_held_next      = 1'b0;
            key_byte_next      = 8'd0;
            line_dead_next     = 1'b0;
            if (!go_echo)
            begin
                echo_count_next    = '0;
                echo_overflow_next = 1'b0;
            end
        end
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_RUN;
            in_bracket_reg    <= 1'b0;
            phase_reg         <= hxd_pkg::PhIdle;
            high_nibble_reg   <= 4'd0;
            pending_valid_reg <= 1'b0;
            pending_error_reg <= 1'b0;
            pending_byte_reg  <= 8'd0;
            key_held_reg      <= 1'b0;
            key_byte_reg      <= 8'd0;
            line_dead_reg     <= 1'b0;
            echo_count_reg    <= '0;
            echo_overflow_reg <= 1'b0;
            echo_idx_reg      <= '0;
            rd_pend_reg       <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            in_bracket_reg    <= in_bracket_next;
            phase_reg         <= phase_next;
            high_nibble_reg   <= high_nibble_next;
            pending_valid_reg <= pending_valid_next;
            pending_error_reg <= pending_error_next;
            pending_byte_reg  <= pending_byte_next;
            key_held_reg      <= key_held_next;
            key_byte_reg      <= key_byte_next;
            line_dead_reg     <= line_dead_next;
            echo_count_reg    <= echo_count_next;
            echo_overflow_reg <= echo_overflow_next;
            echo_idx_reg      <= echo_idx_next;
            rd_pend_reg       <= rd_pend_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        out_kind_reg  <= out_kind_next;
        out_last_reg  <= out_last_next;
        out_trunc_reg <= out_trunc_next;
    end

    // Replay only runs over a non-empty store
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ECHO) |-> (echo_count_reg != '0))
        else $error("echo replay with empty store");

    // Fill count never passes the store capacity
    assert property (@(posedge clk) disable iff (!rst_n)
        echo_count_reg <= hxd_pkg::count_t'(hxd_pkg::EchoCap))
        else $error("echo count beyond capacity");

    // A dead line holds no pending commit
    assert property (@(posedge clk) disable iff (!rst_n)
        line_dead_reg |-> !pending_valid_reg)
        else $error("pending commit on dead line");

    // Finishing the replay clears the echo bookkeeping
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ECHO && state_next == ST_RUN)
        |=> (echo_count_reg == '0 && !echo_overflow_reg))
        else $error("echo state not cleared after replay");

endmodule

[design/hxd_ram.sv]
// Generic simple dual-port RAM with one write port and a registered read port.
module hxd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                 clk,
    input  logic                                 wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                     wr_data,
    input  logic                                 rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                     rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read, held while not enabled
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[sim/hxd_decode_checker.sv]
// Result checker for the hex escape XOR line decoder: predicts and compares.
`timescale 1ns / 1ps

module hxd_decode_checker (
    input  logic   clk,
    input  logic   rst_n,
    hxd_char_if    chars,
    hxd_result_if  results,
    output int     mismatches,
    output int     outstanding
);

    typedef struct packed {
        logic [7:0] data;
        logic [1:0] kind;
        logic       last;
        logic       truncated;
    } result_t;

    result_t predicted_results[$];
    int      fail_count = 0;
    int      queued = 0;

    // Per-line decoder state
    logic       in_bracket;
    logic [1:0] esc_phase;
    logic [3:0] hi_nib;
    logic       pend_valid;
    logic       pend_err;
    logic [7:0] pend_byte;
    logic       key_held;
    logic [7:0] key_byte;
    logic       line_dead;
    logic [7:0] echo_mem [hxd_pkg::StoreDepth];
    int         echo_len;
    logic       echo_ovf;

    assign mismatches  = fail_count;
    assign outstanding = queued;

    // Digit value of a hex character, -1 when it is not one
    function automatic int hex_digit(input logic [7:0] c);
        if (c >= "0" && c <= "9") return int'(c) - int'("0");
        if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
        if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
        return -1;
    endfunction

    task automatic add_result(input logic [7:0] d, input logic [1:0] k,
                              input logic l, input logic t);
        result_t r;
        r.data      = d;
        r.kind      = k;
        r.last      = l;
        r.truncated = t;
        predicted_results.insert(predicted_results.size(), r);
    endtask

    task automatic clear_line();
        in_bracket = 1'b0;
        esc_phase  = hxd_pkg::PhIdle;
        hi_nib     = 4'd0;
        pend_valid = 1'b0;
        pend_err   = 1'b0;
        pend_byte  = 8'd0;
        key_held   = 1'b0;
        key_byte   = 8'd0;
        line_dead  = 1'b0;
        echo_len   = 0;
        echo_ovf   = 1'b0;
    endtask

    // Commit any pending byte; unless that kills the line, store the character and advance the escape parser
    task automatic take_kept(input logic [7:0] c);
        int v;
        if (pend_valid)
        begin
            pend_valid = 1'b0;
            if (pend_err)
            begin
                pend_err  = 1'b0;
                line_dead = 1'b1;
                add_result(8'd0, hxd_pkg::KindError, 1'b0, 1'b0);
                return;
            end
            if (!key_held)
            begin
                key_held = 1'b1;
                key_byte = pend_byte;
            end
            else
            begin
                add_result(pend_byte ^ key_byte, hxd_pkg::KindByte, 1'b0, 1'b0);
            end
        end
        if (echo_len < hxd_pkg::EchoCap)
        begin
            echo_mem[echo_len] = c;
            echo_len++;
        end
        else
        begin
            echo_ovf = 1'b1;
        end
        case (esc_phase)
            hxd_pkg::PhIdle:
            begin
                if (c == hxd_pkg::ChSlash) esc_phase = hxd_pkg::PhSlash;
            end
            hxd_pkg::PhSlash:
            begin
                if (c == hxd_pkg::ChX) esc_phase = hxd_pkg::PhX;
                else if (c != hxd_pkg::ChSlash) esc_phase = hxd_pkg::PhIdle;
            end
            hxd_pkg::PhX:
            begin
                v = hex_digit(c);
                pend_err  = (v < 0);
                hi_nib    = (v < 0) ? 4'd0 : v[3:0];
                esc_phase = hxd_pkg::PhFirst;
            end
            default:
            begin
                v = hex_digit(c);
                pend_byte  = (v < 0) ? {4'd0, hi_nib} : {hi_nib, v[3:0]};
                pend_valid = 1'b1;
                esc_phase  = hxd_pkg::PhIdle;
            end
        endcase
    endtask

    // Work out the results that one accepted character causes
    task automatic decode_char(input logic [7:0] c, input logic eol);
        if (c == hxd_pkg::ChOpen)
        begin
            in_bracket = 1'b1;
        end
        else if (c == hxd_pkg::ChClose)
        begin
            in_bracket = 1'b0;
        end
        else if (!in_bracket && !line_dead)
        begin
            take_kept(c);
        end
        if (eol)
        begin
            if (!line_dead && !key_held && echo_len > 0)
            begin
                for (int i = 0; i < echo_len; i++)
                    add_result(echo_mem[i], hxd_pkg::KindEcho, i + 1 == echo_len,
                               echo_ovf);
            end
            else
            begin
                add_result(8'd0, hxd_pkg::KindEnd, 1'b1, 1'b0);
            end
            clear_line();
        end
    endtask

    // Predict on accepted characters, compare accepted results in order
    always @(posedge clk or negedge rst_n)
    begin
        result_t got;
        result_t want;
        if (!rst_n)
        begin
            clear_line();
            predicted_results.delete();
        end
        else
        begin
            if (chars.valid && chars.ready)
                decode_char(chars.ch, chars.line_end);
            if (results.valid && results.ready)
            begin
                got.data      = results.data;
                got.kind      = results.kind;
                got.last      = results.last;
                got.truncated = results.truncated;
                if (predicted_results.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: unexpected result data=%02h kind=%0d last=%b truncated=%b",
                             $time, got.data, got.kind, got.last, got.truncated);
                end
                else
                begin
                    want = predicted_results.pop_front();
                    // fields shown as data/kind/last/truncated
                    if (got !== want)
                    begin
                        fail_count++;
                        $display("%0t: expected %02h/%0d/%b/%b actual %02h/%0d/%b/%b",
                                 $time, want.data, want.kind, want.last, want.truncated,
                                 got.data, got.kind, got.last, got.truncated);
                    end
                end
            end
        end
        queued = predicted_results.size();
    end

endmodule

[sim/hex_escape_xor_line_decoder_test.sv]
// Stimulus and verdict for the hex escape XOR line decoder.
`timescale 1ns / 1ps

module hex_escape_xor_line_decoder_test;

    localparam int RandomItems = 400;
    localparam int LongHold    = 300;
    localparam int DrainCycles = 100;
    localparam int Limit       = 200000;

    typedef enum int { AlwaysReady, CoinFlip, EveryThird, MostlyReady } stall_t;
    typedef enum int { DecodeLine, EchoLine, BrokenLine, NoiseLine } flavor_t;

    logic clk = 1'b0;
    logic rst_n;

    hxd_char_if   chars_bus ();
    hxd_result_if results_bus ();

    int         mismatches;
    int         outstanding;
    int         burst_left = 0;
    bit         hold_off = 1'b0;
    int         cycle_count = 0;
    logic [7:0] line_chars[$];
    string      bad_first = "+- gGz:/@x\\";

    hex_escape_xor_line_decoder uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .chars   (chars_bus),
        .results (results_bus)
    );

    hxd_decode_checker checker_inst (
        .clk         (clk),
        .rst_n       (rst_n),
        .chars       (chars_bus),
        .results     (results_bus),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Random kept character that is neither a backslash nor a bracket
    function automatic logic [7:0] plain_char();
        logic [7:0] c;
        do c = 8'($urandom_range(0, 255));
        while (c == hxd_pkg::ChSlash || c == hxd_pkg::ChOpen || c == hxd_pkg::ChClose);
        return c;
    endfunction

    function automatic logic [7:0] hex_char();
        int v;
        v = $urandom_range(0, 15);
        if (v < 10) return 8'(8'h30 + v);
        return $urandom_range(0, 1) ? 8'(8'h41 + v - 10) : 8'(8'h61 + v - 10);
    endfunction

    // Append one character to the line being built
    task automatic add_char(input logic [7:0] c);
        line_chars.insert(line_chars.size(), c);
    endtask

    task automatic load_text(input string s);
        for (int i = 0; i < s.len(); i++)
            add_char(s[i]);
    endtask

    // Offer one item, idling between bursts, and hold it until accepted
    task automatic send_char(input logic [7:0] c, input logic eol);
        if (burst_left == 0)
        begin
            chars_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = ($urandom_range(0, 7) == 0) ? 150 : $urandom_range(1, 16);
        end
        chars_bus.valid    <= 1'b1;
        chars_bus.ch       <= c;
        chars_bus.line_end <= eol;
        do @(posedge clk); while (!chars_bus.ready);
        burst_left--;
    endtask

    task automatic send_line();
        for (int i = 0; i < line_chars.size(); i++)
            send_char(line_chars[i], i == line_chars.size() - 1);
        line_chars.delete();
    endtask

    // Stop offering until every predicted result has come out
    task automatic wait_drained();
        chars_bus.valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
    endtask

    // Receiver: stall on a changing pattern, with one long hold-off on request
    initial
    begin
        stall_t stall_mode;
        int     cyc;
        bit     held;
        stall_mode = AlwaysReady;
        cyc = 0;
        held = 1'b0;
        results_bus.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            cyc++;
            if (cyc % 48 == 0) stall_mode = stall_t'($urandom_range(0, 3));
            if (hold_off && !held)
            begin
                held = 1'b1;
                results_bus.ready <= 1'b0;
                repeat (LongHold - 1) @(posedge clk);
            end
            else
            begin
                case (stall_mode)
                    AlwaysReady: results_bus.ready <= 1'b1;
                    CoinFlip:    results_bus.ready <= 1'($urandom_range(0, 1));
                    EveryThird:  results_bus.ready <= (cyc % 3 == 0);
                    default:     results_bus.ready <= ($urandom_range(0, 9) != 0);
                endcase
            end
        end
    end

    // Watchdog: end the run if it stalls
    initial
    begin
        while (cycle_count < Limit)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("hex_escape_xor_line_decoder_test: errors");
        $finish;
    end

    // Stimulus and verdict
    initial
    begin
        int      random_chars;
        int      line_no;
        int      n_esc;
        int      len;
        int      r;
        flavor_t flavor;
        random_chars = 0;
        line_no = 0;
        rst_n <= 1'b0;
        chars_bus.valid    <= 1'b0;
        chars_bus.ch       <= 8'd0;
        chars_bus.line_end <= 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Key, XOR output, lone first digit, uncommitted tail escape
        load_text("\\x4A\\x7g\\x12");
        send_line();
        // Sign as first pair character: malformed, rest ignored
        load_text("\\x-1q");
        send_line();
        // Echo with extreme bytes, dropped brackets, doubled backslash
        add_char(8'h00);
        load_text("[k]");
        add_char(8'hFF);
        load_text("\\\\y");
        send_line();
        // Nothing kept: end marker only
        load_text("[");
        send_line();
        wait_drained();

        while (random_chars < RandomItems)
        begin
            r = $urandom_range(0, 99);
            flavor = (r < 45) ? DecodeLine : (r < 70) ? EchoLine :
                     (r < 85) ? BrokenLine : NoiseLine;
            if (line_no == 5 || line_no == 27) flavor = EchoLine;
            if (line_no == 8) hold_off = 1'b1;
            if (line_no == 20) wait_drained();
            case (flavor)
                DecodeLine:
                begin
                    n_esc = $urandom_range(1, 5);
                    for (int k = 0; k < n_esc; k++)
                    begin
                        repeat ($urandom_range(0, 3)) add_char(plain_char());
                        // a bracketed escape is dropped whole
                        if ($urandom_range(0, 5) == 0) load_text("[\\x9]");
                        if ($urandom_range(0, 7) == 0) add_char(hxd_pkg::ChSlash);
                        load_text("\\x");
                        add_char(hex_char());
                        add_char(($urandom_range(0, 5) == 0) ? plain_char() : hex_char());
                    end
                    // without a trailing character the last byte stays uncommitted
                    if ($urandom_range(0, 3) != 0) add_char(plain_char());
                end
                EchoLine:
                begin
                    len = (line_no == 5) ? $urandom_range(66, 80) :
                          (line_no == 27) ? hxd_pkg::LineMax : $urandom_range(1, 20);
                    repeat (len) add_char(plain_char());
                end
                BrokenLine:
                begin
                    repeat ($urandom_range(0, 2)) add_char(plain_char());
                    load_text("\\x");
                    add_char(bad_first[$urandom_range(0, bad_first.len() - 1)]);
                    repeat ($urandom_range(1, 6))
                        add_char(8'($urandom_range(0, 255)));
                end
                default:
                begin
                    repeat ($urandom_range(1, 16))
                    begin
                        if ($urandom_range(0, 5) == 0) load_text("\\x");
                        add_char(8'($urandom_range(0, 255)));
                    end
                end
            endcase
            random_chars += line_chars.size();
            line_no++;
            send_line();
        end

        wait_drained();
        repeat (DrainCycles) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("hex_escape_xor_line_decoder_test: clean");
        else
            $display("hex_escape_xor_line_decoder_test: errors");
        $finish;
    end

endmodule
